FILE: rtl/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg
// Types, constants and helpers shared by the sequential stream generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int ADDR_W    = 48;
    localparam int FRAC_W    = 16;
    localparam int UNIT_W    = 8;
    localparam int SIZE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = ADDR_W;

    localparam int RF_W   = FRAC_W + 1;
    localparam int N_W    = 2 * FRAC_W + 1;
    localparam int MA_W   = FRAC_W + 1;
    localparam int PROD_W = MA_W + ADDR_W;
    localparam int ACC_W  = N_W + ADDR_W;
    localparam int SEQ_W  = ADDR_W + 1;

    // size thresholds, ceil(p / 100 * 2^F)
    localparam logic [FRAC_W-1:0] TH_40 = FRAC_W'(((longint'(40) << FRAC_W) + 99) / 100);
    localparam logic [FRAC_W-1:0] TH_64 = FRAC_W'(((longint'(64) << FRAC_W) + 99) / 100);
    localparam logic [FRAC_W-1:0] TH_84 = FRAC_W'(((longint'(84) << FRAC_W) + 99) / 100);
    localparam logic [FRAC_W-1:0] TH_92 = FRAC_W'(((longint'(92) << FRAC_W) + 99) / 100);

    localparam logic [SIZE_W-1:0] SZ_8   = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] SZ_16  = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] SZ_32  = SIZE_W'(32);
    localparam logic [SIZE_W-1:0] SZ_64  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] SZ_128 = SIZE_W'(128);

    localparam logic [RF_W-1:0]   RST_READ_FRAC = RF_W'(longint'(1) << (FRAC_W - 1));
    localparam logic [ADDR_W-1:0] RST_VOLUME    = ADDR_W'(1048576);
    localparam logic [FRAC_W-1:0] RST_RUN_LEN   = FRAC_W'(((longint'(1) << FRAC_W) + 5) / 10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_ID,
        CFG_READ_FRAC,
        CFG_VOLUME,
        CFG_CENTRE,
        CFG_SPREAD,
        CFG_STRIDE,
        CFG_RUN_LEN
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MRS,
        ST_NCALC,
        ST_MNL,
        ST_MNH,
        ST_ACC,
        ST_CLAMP,
        ST_LIMIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_RS,
        MUL_NL,
        MUL_NH,
        MUL_RL
    } t_mul_sel;

    typedef struct packed {
        logic [FRAC_W-1:0] rand_size;
        logic [FRAC_W-1:0] rand_start;
        logic [FRAC_W-1:0] rand_dir;
    } t_req_in;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              is_write;
        logic [UNIT_W-1:0] unit_out;
        logic [SIZE_W-1:0] transfer_blocks;
    } t_cmd_out;

    typedef struct packed {
        logic     cap_in;
        logic     check;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     calc_n;
        logic     acc_load;
        logic     acc_add;
        logic     clamp;
        logic     limit;
        logic     emit;
    } t_ctl;

    typedef struct packed {
        logic new_run;
        logic out_free;
    } t_sts;

    function automatic logic [SIZE_W-1:0] smix_size(input logic [FRAC_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r < TH_40) begin
            s = SZ_8;
        end else if (r < TH_64) begin
            s = SZ_16;
        end else if (r < TH_84) begin
            s = SZ_32;
        end else if (r < TH_92) begin
            s = SZ_64;
        end else begin
            s = SZ_128;
        end
        return s;
    endfunction

endpackage

FILE: rtl/sequential_io_stream_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_io_stream_generator_unit
// Turns random fractions into sequential storage commands with SMIX sizes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  request  | in        | i_in_valid / o_in_stall | i_in_data   (t_req_in)
//  command  | out       | o_out_valid/i_out_stall | o_out_data  (t_cmd_out)
//  config   | in        | i_cfg_we                | i_cfg_addr, i_cfg_data
//
//  Inside a run a request goes from the address check straight to emit;
//  a new run adds four passes through the one shared 17x48 multiplier.
//  Synchronous active-low reset; the first command always starts a new run.
//  A finished command sits in the output register; the next request is
//  taken while it waits, and the following one waits for that slot.
// ----------------------------------------------------------------------------
module sequential_io_stream_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [ssg_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ssg_pkg::t_req_in                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ssg_pkg::t_cmd_out                o_out_data
);

    ssg_pkg::t_ctl w_ctl;
    ssg_pkg::t_sts w_sts;

    ssg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl)
    );

    ssg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctl.emit))
        else $error("command valid without emit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> (!o_out_valid || !i_out_stall))
        else $error("emit over a stalled command");

    a_size_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot(o_out_data.transfer_blocks)
                         && o_out_data.transfer_blocks[2:0] == 3'b000))
        else $error("illegal transfer size");

endmodule

FILE: rtl/ssg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_ctrl
// Sequencer: steps each request through address check, new-run math when a new run starts, and emit.
// ----------------------------------------------------------------------------
module ssg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ssg_pkg::t_sts  i_sts,
    output logic           o_in_stall,
    output ssg_pkg::t_ctl  o_ctl
);

    ssg_pkg::t_state r_state;
    ssg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ssg_pkg::ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_ctl         = '0;
        o_ctl.mul_sel = ssg_pkg::MUL_RS;
        unique case (r_state)
            ssg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cap_in = 1'b1;
                    n_state      = ssg_pkg::ST_CHECK;
                end
            end
            ssg_pkg::ST_CHECK: begin
                o_ctl.check = 1'b1;
                n_state     = i_sts.new_run ? ssg_pkg::ST_MRS : ssg_pkg::ST_EMIT;
            end
            ssg_pkg::ST_MRS: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = ssg_pkg::MUL_RS;
                n_state       = ssg_pkg::ST_NCALC;
            end
            ssg_pkg::ST_NCALC: begin
                o_ctl.calc_n = 1'b1;
                n_state      = ssg_pkg::ST_MNL;
            end
            ssg_pkg::ST_MNL: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = ssg_pkg::MUL_NL;
                n_state       = ssg_pkg::ST_MNH;
            end
            ssg_pkg::ST_MNH: begin
                o_ctl.mul_en   = 1'b1;
                o_ctl.mul_sel  = ssg_pkg::MUL_NH;
                o_ctl.acc_load = 1'b1;
                n_state        = ssg_pkg::ST_ACC;
            end
            ssg_pkg::ST_ACC: begin
                o_ctl.acc_add = 1'b1;
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = ssg_pkg::MUL_RL;
                n_state       = ssg_pkg::ST_CLAMP;
            end
            ssg_pkg::ST_CLAMP: begin
                o_ctl.clamp = 1'b1;
                n_state     = ssg_pkg::ST_LIMIT;
            end
            ssg_pkg::ST_LIMIT: begin
                o_ctl.limit = 1'b1;
                n_state     = ssg_pkg::ST_EMIT;
            end
            ssg_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = ssg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ssg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_dp
// Datapath: config registers, run state, shared 17x48 multiplier, output reg.
// ----------------------------------------------------------------------------
module ssg_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [ssg_pkg::CFG_DW-1:0]       i_cfg_data,
    input  ssg_pkg::t_req_in                 i_in_data,
    input  ssg_pkg::t_ctl                    i_ctl,
    output ssg_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ssg_pkg::t_cmd_out                o_out_data
);

    localparam int AW = ssg_pkg::ADDR_W;
    localparam int FW = ssg_pkg::FRAC_W;

    // configuration
    logic [ssg_pkg::UNIT_W-1:0] r_unit;
    logic [ssg_pkg::RF_W-1:0]   r_read_frac;
    logic [AW-1:0]              r_volume;
    logic [FW-1:0]              r_centre;
    logic [FW-1:0]              r_spread;
    logic [FW-1:0]              r_stride;
    logic [FW-1:0]              r_run_len;

    // run state
    logic [AW-1:0]                 r_prev_addr;
    logic [ssg_pkg::SIZE_W-1:0]    r_prev_size;
    logic [AW-1:0]                 r_limit;
    logic                          r_out_valid;

    // working registers
    ssg_pkg::t_req_in              r_in;
    logic [ssg_pkg::SIZE_W-1:0]    r_size;
    logic [ssg_pkg::SEQ_W-1:0]     r_seq;
    logic [ssg_pkg::PROD_W-1:0]    r_prod;
    logic [ssg_pkg::N_W-1:0]       r_n;
    logic [ssg_pkg::ACC_W-1:0]     r_acc;
    logic [AW-1:0]                 r_start;
    logic [AW-1:0]                 r_addr;
    ssg_pkg::t_cmd_out             r_out;

    logic [ssg_pkg::SEQ_W:0]       w_seq_end;
    logic                          w_new_run;
    logic [ssg_pkg::MA_W-1:0]      w_mul_a;
    logic [AW-1:0]                 w_mul_b;
    logic [ssg_pkg::PROD_W-1:0]    w_prod;
    logic [ssg_pkg::N_W-1:0]       w_pos;
    logic [ssg_pkg::N_W-1:0]       w_neg;
    logic [AW:0]                   w_a_raw;
    logic [AW+1:0]                 w_a_end;
    logic [AW-1:0]                 w_len;
    logic [AW:0]                   w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit      <= '0;
            r_read_frac <= ssg_pkg::RST_READ_FRAC;
            r_volume    <= ssg_pkg::RST_VOLUME;
            r_centre    <= '0;
            r_spread    <= '0;
            r_stride    <= '0;
            r_run_len   <= ssg_pkg::RST_RUN_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ssg_pkg::CFG_UNIT_ID:   r_unit      <= i_cfg_data[ssg_pkg::UNIT_W-1:0];
                ssg_pkg::CFG_READ_FRAC: r_read_frac <= i_cfg_data[ssg_pkg::RF_W-1:0];
                ssg_pkg::CFG_VOLUME:    r_volume    <= i_cfg_data[AW-1:0];
                ssg_pkg::CFG_CENTRE:    r_centre    <= i_cfg_data[FW-1:0];
                ssg_pkg::CFG_SPREAD:    r_spread    <= i_cfg_data[FW-1:0];
                ssg_pkg::CFG_STRIDE:    r_stride    <= i_cfg_data[FW-1:0];
                ssg_pkg::CFG_RUN_LEN:   r_run_len   <= i_cfg_data[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequential candidate end, minus one: compares against limit directly
    assign w_seq_end = (ssg_pkg::SEQ_W+1)'(r_seq)
                     + (ssg_pkg::SEQ_W+1)'(r_size - ssg_pkg::SIZE_W'(1));
    assign w_new_run = (w_seq_end > (ssg_pkg::SEQ_W+1)'(r_limit));

    always_comb begin
        unique case (i_ctl.mul_sel)
            ssg_pkg::MUL_RS: begin
                w_mul_a = ssg_pkg::MA_W'(r_in.rand_start);
                w_mul_b = AW'(r_spread);
            end
            ssg_pkg::MUL_NL: begin
                w_mul_a = r_n[ssg_pkg::MA_W-1:0];
                w_mul_b = r_volume;
            end
            ssg_pkg::MUL_NH: begin
                w_mul_a = ssg_pkg::MA_W'(r_n[ssg_pkg::N_W-1:ssg_pkg::MA_W]);
                w_mul_b = r_volume;
            end
            ssg_pkg::MUL_RL: begin
                w_mul_a = ssg_pkg::MA_W'(r_run_len);
                w_mul_b = r_volume;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = ssg_pkg::PROD_W'(w_mul_a) * ssg_pkg::PROD_W'(w_mul_b);

    assign w_pos   = ssg_pkg::N_W'({r_centre, FW'(0)}) + ssg_pkg::N_W'(r_prod[2*FW-1:0]);
    assign w_neg   = ssg_pkg::N_W'({r_spread, (FW-1)'(0)});

    assign w_a_raw = r_acc[ssg_pkg::ACC_W-1:2*FW];
    assign w_a_end = (AW+2)'(w_a_raw) + (AW+2)'(r_size);

    assign w_len   = r_prod[FW+AW-1:FW];
    assign w_lim   = (AW+1)'(r_start) + (AW+1)'(w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_addr <= AW'(1);
            r_prev_size <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.limit) begin
                if (r_volume == '0) begin
                    r_limit <= '0;
                end else if (w_lim >= (AW+1)'(r_volume)) begin
                    r_limit <= r_volume - AW'(1);
                end else begin
                    r_limit <= w_lim[AW-1:0];
                end
            end
            if (i_ctl.emit) begin
                r_prev_addr <= r_addr;
                r_prev_size <= r_size;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_in) begin
            r_in   <= i_in_data;
            r_size <= ssg_pkg::smix_size(i_in_data.rand_size);
            r_seq  <= ssg_pkg::SEQ_W'(r_prev_addr) + ssg_pkg::SEQ_W'(r_prev_size)
                    + ssg_pkg::SEQ_W'(r_stride);
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.calc_n) begin
            r_n <= (w_pos < w_neg) ? '0 : w_pos - w_neg;
        end
        if (i_ctl.acc_load) begin
            r_acc <= ssg_pkg::ACC_W'(r_prod);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + (ssg_pkg::ACC_W'(r_prod) << ssg_pkg::MA_W);
        end
        if (i_ctl.clamp) begin
            if (w_a_end > (AW+2)'(r_volume)) begin
                r_start <= (r_volume >= AW'(r_size)) ? r_volume - AW'(r_size) : '0;
            end else begin
                r_start <= w_a_raw[AW-1:0];
            end
        end
        if (i_ctl.check) begin
            r_addr <= r_seq[AW-1:0];
        end else if (i_ctl.limit) begin
            r_addr <= r_start;
        end
        if (i_ctl.emit) begin
            r_out.block_address   <= r_addr;
            r_out.is_write        <= !(ssg_pkg::RF_W'(r_in.rand_dir) < r_read_frac);
            r_out.unit_out        <= r_unit;
            r_out.transfer_blocks <= r_size;
        end
    end

    assign o_sts.new_run  = w_new_run;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule
